// ===== sv/fsqa_pkg.sv =====
// ----------------------------------------------------------------------------
// fsqa_pkg
// types and constants shared by the flow steering and admission block
// ----------------------------------------------------------------------------
package fsqa_pkg;

  // queue array dimensions
  localparam int unsigned MAX_WORKERS   = 8;
  localparam int unsigned NUM_PROTOCOLS = 32;

  typedef enum logic [1:0] {
    OP_ARRIVE = 2'd0,
    OP_DRAIN  = 2'd1,
    OP_IDLE   = 2'd2,
    OP_STATS  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_DIRECT  = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_DROPPED = 3'd2,
    ST_DRAINED = 3'd3,
    ST_IDLE    = 3'd4,
    ST_STATS   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_DIRECT = 2'd0,
    CFG_WORKERS = 2'd1,
    CFG_LIMIT  = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEER,
    S_READ,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [4:0]  protocol;
    logic [31:0] source_id;
    logic [31:0] flow_id;
    logic        flow_valid;
    logic [2:0]  current_worker;
    logic [2:0]  target_worker;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  worker_index;
    logic        signal_wakeup;
    logic [15:0] queue_length;
    logic [15:0] watermark;
    logic [31:0] dispatched_count;
    logic [31:0] dropped_count;
    logic [31:0] queued_count;
    logic [31:0] handled_count;
    logic [20:0] pending_total;
  } rsp_t;

  // one queue entry of the counter memory
  typedef struct packed {
    logic [15:0] occ;
    logic [15:0] mark;
    logic [31:0] disp;
    logic [31:0] drop;
    logic [31:0] enq;
    logic [31:0] hand;
  } entry_t;

endpackage

// ===== sv/fsqa_if.sv =====
// ----------------------------------------------------------------------------
// fsqa_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface fsqa_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/flow_steer_queue_admission.sv =====
// ----------------------------------------------------------------------------
// flow_steer_queue_admission
// steers descriptors to worker queues and keeps occupancy and counters
// ----------------------------------------------------------------------------
// sequence: an item is accepted, its counter entry is read, modified and, for
//   arrivals and drains, written back, and the result is registered; a steered
//   arrival first runs the bit serial modulo (32 steps) when several workers are
//   active; no new item is accepted until the previous result has been taken
// reset: counters read zero via per entry valid bits, no sweep; flags clear at reset
module flow_steer_queue_admission (
  input  logic       clk_i,
  input  logic       rst_ni,
  fsqa_if.sink       in_if,
  fsqa_if.source     out_if,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import fsqa_pkg::*;

  localparam int unsigned WW    = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned PW    = (NUM_PROTOCOLS > 1) ? $clog2(NUM_PROTOCOLS) : 1;
  localparam int unsigned DEPTH = MAX_WORKERS * NUM_PROTOCOLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic        direct_q;
  logic [3:0]  wcount_q;
  logic [15:0] limit_q;

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q;
  logic [WW-1:0] w_q, w_d;
  logic [PW-1:0] p;
  logic [PW-1:0] p_rd;
  logic [20:0]   pend_q [MAX_WORKERS];
  logic          sig_q  [MAX_WORKERS];

  logic [3:0]  nwork;
  logic        st_start, st_done;
  logic [2:0]  st_w;
  logic        rd, we;
  entry_t      rdat, wdat;
  rsp_t        rsp_d;
  logic [20:0] pend_new;
  logic        sig_new;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direct_q <= 1'b1;
      wcount_q <= 4'd1;
      limit_q  <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DIRECT:  direct_q <= cfg_data_i[0];
        CFG_WORKERS: wcount_q <= cfg_data_i[3:0];
        CFG_LIMIT:   limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective worker count, clamped
  always_comb begin
    nwork = wcount_q;
    if (nwork == 4'd0) nwork = 4'd1;
    if (32'(nwork) > MAX_WORKERS) nwork = 4'(MAX_WORKERS);
  end

  assign p = PW'(req_q.protocol % NUM_PROTOCOLS);
  // protocol for the read: straight from the input at the transfer cycle
  assign p_rd = acc ? PW'(in_if.data.protocol % NUM_PROTOCOLS) : p;

  fsqa_steer u_steer (
    .clk_i, .rst_ni,
    .start_i (st_start),
    .key_i   (in_if.data.source_id ^ (in_if.data.flow_valid ? in_if.data.flow_id : '0)),
    .count_i (nwork),
    .done_o  (st_done),
    .worker_o(st_w)
  );

  fsqa_queue_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk_i, .rst_ni,
    .rd_i   (rd),
    .raddr_i(AW'(32'(w_d) * NUM_PROTOCOLS + 32'(p_rd))),
    .we_i   (we),
    .waddr_i(AW'(32'(w_q) * NUM_PROTOCOLS + 32'(p))),
    .wdata_i(wdat),
    .rdata_o(rdat)
  );

  assign in_if.ready = (state_q == S_IDLE) && !out_if.valid;
  wire   acc = in_if.valid && in_if.ready;
  wire   steered = (in_if.data.opcode == OP_ARRIVE) && !direct_q && (nwork != 4'd1);
  assign st_start = acc && steered;

  // sequencer: worker pick, memory read, modify and write back
  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    rd      = 1'b0;
    if (state_q == S_IDLE) begin
      if (acc) begin
        if (in_if.data.opcode != OP_ARRIVE) w_d = WW'(in_if.data.target_worker % MAX_WORKERS);
        else if (direct_q) w_d = WW'(in_if.data.current_worker % MAX_WORKERS);
        else w_d = '0;
      end
    end
    unique case (state_q)
      S_IDLE: if (acc && !steered) begin state_d = S_READ; rd = 1'b1; end
              else if (acc) state_d = S_STEER;
      S_STEER: ;
      S_READ: state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (st_done) begin
      w_d = WW'(st_w);
      rd = 1'b1;
      state_d = S_READ;
    end
  end

  // modify the entry read back
  always_comb begin
    wdat     = rdat;
    we       = 1'b0;
    pend_new = pend_q[w_q];
    sig_new  = sig_q[w_q];
    rsp_d    = rsp_q;
    rsp_d.worker_index  = 3'(w_q);
    rsp_d.signal_wakeup = 1'b0;
    rsp_d.status        = ST_STATS;
    rsp_d.queue_length  = rdat.occ;
    if (state_q == S_READ) begin
      case (opcode_e'(req_q.opcode))
        OP_ARRIVE: begin
          we = 1'b1;
          if (direct_q) begin
            rsp_d.status = ST_DIRECT;
            wdat.disp = rdat.disp + 32'd1;
            wdat.hand = rdat.hand + 32'd1;
          end else if (rdat.occ < limit_q) begin
            rsp_d.status = ST_QUEUED;
            wdat.occ = rdat.occ + 16'd1;
            if (wdat.occ > rdat.mark) wdat.mark = wdat.occ;
            wdat.enq = rdat.enq + 32'd1;
            pend_new = pend_q[w_q] + 21'd1;
            rsp_d.signal_wakeup = !sig_q[w_q];
            sig_new = 1'b1;
            rsp_d.queue_length = wdat.occ;
          end else begin
            rsp_d.status = ST_DROPPED;
            wdat.drop = rdat.drop + 32'd1;
          end
        end
        OP_DRAIN: begin
          we = 1'b1;
          rsp_d.status = ST_DRAINED;
          wdat.occ  = '0;
          wdat.hand = rdat.hand + 32'(rdat.occ);
          pend_new  = pend_q[w_q] - 21'(rdat.occ);
          rsp_d.signal_wakeup = pend_new != '0;
        end
        OP_IDLE: begin
          rsp_d.status = ST_IDLE;
          if (pend_q[w_q] == '0) sig_new = 1'b0;
          rsp_d.signal_wakeup = pend_q[w_q] != '0;
        end
        default: begin
          rsp_d.signal_wakeup = sig_q[w_q];
        end
      endcase
      rsp_d.watermark        = wdat.mark;
      rsp_d.dispatched_count = wdat.disp;
      rsp_d.dropped_count    = wdat.drop;
      rsp_d.queued_count     = wdat.enq;
      rsp_d.handled_count    = wdat.hand;
      rsp_d.pending_total    = pend_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      w_q     <= '0;
      out_if.valid <= 1'b0;
      for (int i = 0; i < MAX_WORKERS; i++) begin
        pend_q[i] <= '0;
        sig_q[i]  <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      if (state_q == S_READ) begin
        pend_q[w_q] <= pend_new;
        sig_q[w_q]  <= sig_new;
        out_if.valid <= 1'b1;
      end else if (out_if.ready) begin
        out_if.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) req_q <= in_if.data;
    if (state_q == S_READ) rsp_q <= rsp_d;
  end

  assign out_if.data = rsp_q;

  // checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_if.ready) else $error("accept while busy");
  a_read_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> out_if.valid) else $error("result missing");
  a_steer_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_done |-> (state_q == S_STEER)) else $error("steer done out of sequence");
endmodule

// ===== sv/fsqa_steer.sv =====
// ----------------------------------------------------------------------------
// fsqa_steer
// picks the worker: key modulo worker count, one bit of the key per step
// ----------------------------------------------------------------------------
module fsqa_steer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] key_i,
  input  logic [3:0]  count_i,
  output logic        done_o,
  output logic [2:0]  worker_o
);
  import fsqa_pkg::*;

  logic [31:0] key_q, key_d;
  logic [3:0]  rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [4:0]  trial;

  // restoring remainder, msb first
  always_comb begin
    key_d  = key_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, key_q[31]};
    if (start_i) begin
      key_d  = key_i;
      rem_d  = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      key_d = {key_q[30:0], 1'b0};
      if (trial >= {1'b0, count_i}) rem_d = 4'(trial - {1'b0, count_i});
      else rem_d = trial[3:0];
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rem_q <= rem_d;
  end

  assign done_o   = busy_q && (cnt_q == 6'd1) && !start_i;
  assign worker_o = rem_d[2:0];
endmodule

// ===== sv/fsqa_queue_mem.sv =====
// ----------------------------------------------------------------------------
// fsqa_queue_mem
// per queue counter memory with registered read and per entry valid bits
// ----------------------------------------------------------------------------
module fsqa_queue_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_i,
  input  logic [AW-1:0]    raddr_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  fsqa_pkg::entry_t wdata_i,
  output fsqa_pkg::entry_t rdata_o
);
  import fsqa_pkg::*;

  entry_t     mem [DEPTH];
  logic       vld_q [DEPTH];
  entry_t     rd_q;
  logic       rv_q;

  // valid bit per entry, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) vld_q[i] <= 1'b0;
      rv_q <= 1'b0;
    end else begin
      if (we_i) vld_q[waddr_i] <= 1'b1;
      if (rd_i) rv_q <= vld_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (rd_i) rd_q <= mem[raddr_i];
  end

  assign rdata_o = rv_q ? rd_q : '0;
endmodule
